### rtl/uvgen_pkg.sv
// ----------------------------------------------------------------------------
// uvgen_pkg
// Shared types, widths and constants of the texture coordinate generator.
// ----------------------------------------------------------------------------
package uvgen_pkg;

	localparam int CORDIC_STAGES = 16;
	localparam int XY_W          = 44;
	localparam int ZA_W          = 28;
	localparam int ANG_W         = 25;
	localparam int ANGV_W        = 26;
	localparam int ANGLE_FRAC    = 24;
	localparam int RAD_W         = 32;
	localparam int ROOT_W        = 32;
	localparam int REM_W         = 34;

	localparam int AU_DLY  = 35;
	localparam int SD_AY   = 34;
	localparam int SD_YNEG = CORDIC_STAGES + 35;
	localparam int SD_POS  = CORDIC_STAGES + 36;
	localparam int SD_LEN  = CORDIC_STAGES + 37;
	localparam int LAT     = CORDIC_STAGES + 40;

	localparam logic [ANG_W-1:0]  HALF_PI_Q24 = 25'd26353590;
	localparam logic [ANGV_W-1:0] PI_Q24      = 26'd52707179;
	localparam logic signed [15:0] EPS_RAW    = 16'sd26;

	localparam logic [1:0] MODE_SPH    = 2'd0;
	localparam logic [1:0] MODE_PLANAR = 2'd1;
	localparam logic [1:0] MODE_BOX    = 2'd2;
	localparam logic [1:0] MODE_NONE   = 2'd3;

	localparam logic [1:0] REG_MODE    = 2'd0;
	localparam logic [1:0] REG_SCALE_U = 2'd1;
	localparam logic [1:0] REG_SCALE_V = 2'd2;

	typedef struct packed {
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
		logic signed [15:0] pos_z;
		logic signed [15:0] normal_x;
		logic signed [15:0] normal_y;
		logic signed [15:0] normal_z;
	} vertex_t;

	typedef struct packed {
		logic signed [31:0] tex_u;
		logic signed [31:0] tex_v;
	} result_t;

	typedef struct packed {
		logic [15:0]        ay;
		logic               yneg;
		logic signed [16:0] pu;
		logic signed [16:0] pv;
	} side_t;

	function automatic logic [15:0] abs16(input logic signed [15:0] v);
		abs16 = v[15] ? 16'(-v) : 16'(v);
	endfunction

	function automatic logic signed [ZA_W-1:0] atan_q24(input logic [4:0] i);
		logic signed [ZA_W-1:0] r;
		case (i)
			5'd0:  r = 28'sd13176795;
			5'd1:  r = 28'sd7778716;
			5'd2:  r = 28'sd4110060;
			5'd3:  r = 28'sd2086331;
			5'd4:  r = 28'sd1047214;
			5'd5:  r = 28'sd524117;
			5'd6:  r = 28'sd262123;
			5'd7:  r = 28'sd131069;
			5'd8:  r = 28'sd65536;
			5'd9:  r = 28'sd32768;
			5'd10: r = 28'sd16384;
			5'd11: r = 28'sd8192;
			5'd12: r = 28'sd4096;
			5'd13: r = 28'sd2048;
			5'd14: r = 28'sd1024;
			5'd15: r = 28'sd512;
			5'd16: r = 28'sd256;
			5'd17: r = 28'sd128;
			5'd18: r = 28'sd64;
			5'd19: r = 28'sd32;
			5'd20: r = 28'sd16;
			5'd21: r = 28'sd8;
			5'd22: r = 28'sd4;
			5'd23: r = 28'sd2;
			default: r = '0;
		endcase
		atan_q24 = r;
	endfunction

endpackage

### rtl/uvgen_isqrt.sv
// ----------------------------------------------------------------------------
// uvgen_isqrt
// Pipelined integer square root of rad * 2^32, one root bit per stage.
// ----------------------------------------------------------------------------
module uvgen_isqrt import uvgen_pkg::*; (
	input  logic              clk,
	input  logic [RAD_W-1:0]  rad,
	output logic [ROOT_W-1:0] root
);

	logic [REM_W-1:0]  rem_q  [ROOT_W];
	logic [ROOT_W-1:0] root_q [ROOT_W];
	logic [RAD_W-1:0]  rad_q  [ROOT_W];

	for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
		logic [REM_W-1:0]  remp;
		logic [ROOT_W-1:0] rootp;
		logic [RAD_W-1:0]  radp;
		logic [REM_W+1:0]  pre;
		logic [REM_W+1:0]  trial;
		logic              ge;

		if (k == 0) begin : g_first
			assign remp  = '0;
			assign rootp = '0;
			assign radp  = rad;
		end else begin : g_next
			assign remp  = rem_q[k-1];
			assign rootp = root_q[k-1];
			assign radp  = rad_q[k-1];
		end

		assign pre   = {remp, radp[RAD_W-1 -: 2]};
		assign trial = {2'b00, rootp, 2'b01};
		assign ge    = (pre >= trial);

		always_ff @(posedge clk) begin
			rem_q[k]  <= ge ? REM_W'(pre - trial) : REM_W'(pre);
			root_q[k] <= {rootp[ROOT_W-2:0], ge};
			rad_q[k]  <= {radp[RAD_W-3:0], 2'b00};
		end
	end

	assign root = root_q[ROOT_W-1];

endmodule

### rtl/uvgen_cordic.sv
// ----------------------------------------------------------------------------
// uvgen_cordic
// Pipelined CORDIC vectoring, one iteration per stage, angle clamped to
// [0, pi/2] in a final register.
// ----------------------------------------------------------------------------
module uvgen_cordic import uvgen_pkg::*; (
	input  logic                   clk,
	input  logic signed [XY_W-1:0] x_in,
	input  logic signed [XY_W-1:0] y_in,
	output logic [ANG_W-1:0]       angle
);

	logic signed [XY_W-1:0] x_q [CORDIC_STAGES];
	logic signed [XY_W-1:0] y_q [CORDIC_STAGES];
	logic signed [ZA_W-1:0] z_q [CORDIC_STAGES];
	logic signed [ZA_W-1:0] zl;
	logic [ANG_W-1:0]       angle_q;

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_iter
		logic signed [XY_W-1:0] xp;
		logic signed [XY_W-1:0] yp;
		logic signed [ZA_W-1:0] zp;

		if (i == 0) begin : g_first
			assign xp = x_in;
			assign yp = y_in;
			assign zp = '0;
		end else begin : g_next
			assign xp = x_q[i-1];
			assign yp = y_q[i-1];
			assign zp = z_q[i-1];
		end

		always_ff @(posedge clk) begin
			if (!yp[XY_W-1]) begin
				x_q[i] <= xp + (yp >>> i);
				y_q[i] <= yp - (xp >>> i);
				z_q[i] <= zp + atan_q24(5'(i));
			end else begin
				x_q[i] <= xp - (yp >>> i);
				y_q[i] <= yp + (xp >>> i);
				z_q[i] <= zp - atan_q24(5'(i));
			end
		end
	end

	assign zl = z_q[CORDIC_STAGES-1];

	always_ff @(posedge clk) begin
		if (zl[ZA_W-1])
			angle_q <= '0;
		else if ($unsigned(zl) > ZA_W'(HALF_PI_Q24))
			angle_q <= HALF_PI_Q24;
		else
			angle_q <= zl[ANG_W-1:0];
	end

	assign angle = angle_q;

endmodule

### rtl/uvgen_scale.sv
// ----------------------------------------------------------------------------
// uvgen_scale
// Two-stage scaler: angle * scale rounded to Q16.16, or position * scale,
// then saturated to 32 bits.
// ----------------------------------------------------------------------------
module uvgen_scale import uvgen_pkg::*; (
	input  logic               clk,
	input  logic [ANGV_W-1:0]  ang,
	input  logic signed [16:0] pos,
	input  logic signed [15:0] sc,
	input  logic               sph,
	output logic signed [31:0] res
);

	logic signed [ANGV_W:0] op;
	logic signed [42:0]     prod_s1;
	logic                   sph_s1;
	logic signed [43:0]     ext;
	logic signed [43:0]     rnd;
	logic signed [43:0]     sh;
	logic signed [31:0]     res_s2;

	assign op = sph ? $signed({1'b0, ang}) : $signed({{(ANGV_W-16){pos[16]}}, pos});

	always_ff @(posedge clk) begin
		prod_s1 <= op * sc;
		sph_s1  <= sph;
	end

	assign ext = {prod_s1[42], prod_s1};
	assign rnd = ext + 44'sd32768;
	assign sh  = sph_s1 ? (rnd >>> 16) : ext;

	always_ff @(posedge clk) begin
		if (sh > 44'sd2147483647)
			res_s2 <= 32'sh7fffffff;
		else if (sh < -44'sd2147483648)
			res_s2 <= 32'sh80000000;
		else
			res_s2 <= sh[31:0];
	end

	assign res = res_s2;

endmodule

### rtl/vertex_uv_texture_coordinate_generator.sv
// ----------------------------------------------------------------------------
// vertex_uv_texture_coordinate_generator
// Texture coordinates from one vertex word: spherical, planar, box or zero.
// ----------------------------------------------------------------------------
// The start-to-done latency is set by the 32-stage square root followed by
//   the second CORDIC pipeline.
// Throughput: one vertex word per cycle; busy is never raised.
// Reset: mode spherical, both scales 1.0, pipeline valid bits cleared.
// The receiver takes each result word in its done cycle and cannot stall.
module vertex_uv_texture_coordinate_generator import uvgen_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  vertex_t     vertex,
	output logic        done,
	output result_t     result,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_idx,
	input  logic [15:0] cfg_data
);

	logic [1:0]         mode_q;
	logic signed [15:0] scale_u_q;
	logic signed [15:0] scale_v_q;
	logic [LAT-1:0]     vld_q;

	logic                near_axis;
	logic [15:0]         anx, any, anz;
	logic                zsel, ysel;
	logic signed [16:0]  x17, y17, nz17;
	logic signed [16:0]  pu, pv;

	logic [15:0]         ax_s1, az_s1;
	side_t               sd_q [SD_LEN];
	logic [31:0]         sqx_s2, sqz_s2;
	logic [RAD_W-1:0]    s_s3;
	logic [ROOT_W-1:0]   root;
	logic [ANG_W-1:0]    ang_a, ang_b;
	logic [ANG_W-1:0]    au_q [AU_DLY];
	logic [ANGV_W-1:0]   angv_q;
	logic signed [31:0]  u_res, v_res;
	logic                sph;
	result_t             result_q;

	assign busy = 1'b0;
	assign sph  = (mode_q == MODE_SPH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_SPH;
			scale_u_q <= 16'sd256;
			scale_v_q <= 16'sd256;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_MODE:    mode_q    <= cfg_data[1:0];
				REG_SCALE_U: scale_u_q <= cfg_data;
				REG_SCALE_V: scale_v_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else
			vld_q <= {vld_q[LAT-2:0], start & ~busy};
	end

	assign near_axis = (vertex.pos_x < EPS_RAW) && (vertex.pos_x > -EPS_RAW) &&
	                   (vertex.pos_z < EPS_RAW) && (vertex.pos_z > -EPS_RAW);
	assign anx  = abs16(vertex.normal_x);
	assign any  = abs16(vertex.normal_y);
	assign anz  = abs16(vertex.normal_z);
	assign zsel = (anz > anx) && (anz > any);
	assign ysel = (any > anx);
	assign x17  = {vertex.pos_x[15], vertex.pos_x};
	assign y17  = {vertex.pos_y[15], vertex.pos_y};
	assign nz17 = -$signed({vertex.pos_z[15], vertex.pos_z});

	always_comb begin
		pu = x17;
		pv = y17;
		case (mode_q)
			MODE_BOX: begin
				if (!zsel && ysel)
					pv = nz17;
				else if (!zsel)
					pu = nz17;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		ax_s1 <= near_axis ? 16'(EPS_RAW) : abs16(vertex.pos_x);
		az_s1 <= near_axis ? 16'(EPS_RAW) : abs16(vertex.pos_z);
		sd_q[0] <= '{ay: abs16(vertex.pos_y), yneg: vertex.pos_y[15], pu: pu, pv: pv};
		for (int k = 1; k < SD_LEN; k++)
			sd_q[k] <= sd_q[k-1];
	end

	always_ff @(posedge clk) begin
		sqx_s2 <= ax_s1 * ax_s1;
		sqz_s2 <= az_s1 * az_s1;
		s_s3   <= sqx_s2 + sqz_s2;
	end

	uvgen_cordic u_cordic_a (
		.clk   (clk),
		.x_in  ($signed(XY_W'({az_s1, {ANGLE_FRAC{1'b0}}}))),
		.y_in  ($signed(XY_W'({ax_s1, {ANGLE_FRAC{1'b0}}}))),
		.angle (ang_a)
	);

	uvgen_isqrt u_isqrt (
		.clk  (clk),
		.rad  (s_s3),
		.root (root)
	);

	uvgen_cordic u_cordic_b (
		.clk   (clk),
		.x_in  ($signed(XY_W'({sd_q[SD_AY].ay, {ANGLE_FRAC{1'b0}}}))),
		.y_in  ($signed(XY_W'(root))),
		.angle (ang_b)
	);

	always_ff @(posedge clk) begin
		au_q[0] <= ang_a;
		for (int k = 1; k < AU_DLY; k++)
			au_q[k] <= au_q[k-1];
		angv_q <= sd_q[SD_YNEG].yneg ? PI_Q24 - {1'b0, ang_b} : {1'b0, ang_b};
	end

	uvgen_scale u_scale_u (
		.clk (clk),
		.ang ({1'b0, au_q[AU_DLY-1]}),
		.pos (sd_q[SD_POS].pu),
		.sc  (scale_u_q),
		.sph (sph),
		.res (u_res)
	);

	uvgen_scale u_scale_v (
		.clk (clk),
		.ang (angv_q),
		.pos (sd_q[SD_POS].pv),
		.sc  (scale_v_q),
		.sph (sph),
		.res (v_res)
	);

	always_ff @(posedge clk) begin
		result_q.tex_u <= (mode_q == MODE_NONE) ? '0 : u_res;
		result_q.tex_v <= (mode_q == MODE_NONE) ? '0 : v_res;
	end

	assign result = result_q;
	assign done   = vld_q[LAT-1];

	a_fixed_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##LAT done)
		else $error("word not delivered at fixed latency");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LAT))
		else $error("result word without accepted vertex");

	a_mode_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(mode_q) == MODE_NONE) |-> (result.tex_u == 0 && result.tex_v == 0))
		else $error("undefined mode must give zero");

endmodule

### tb/vertex_uv_texture_coordinate_generator_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertex_uv_texture_coordinate_generator_test
// Streams vertex words through the generator over a series of mode and scale
// settings, predicts every (u, v) word in fixed point and checks each done
// word in order against the oldest prediction.
// ----------------------------------------------------------------------------
module vertex_uv_texture_coordinate_generator_test;
	import uvgen_pkg::*;

	localparam logic [1:0] REG_UNUSED = 2'd3;
	localparam int NUM_PHASES = 16;
	localparam int RAND_PER_PHASE = 110;
	localparam longint EPS_Q8 = 26;
	localparam longint HALF_PI = 26353590;
	localparam longint PI_VAL = 52707179;
	localparam longint ATAN_TAB [24] = '{
		13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
		65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
		256, 128, 64, 32, 16, 8, 4, 2};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	vertex_t     vertex = '0;
	logic        done;
	result_t     result;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_idx = REG_MODE;
	logic [15:0] cfg_data = '0;

	vertex_t pending_words[$];
	result_t expected_uv[$];
	logic [1:0] mode_m = MODE_SPH;
	longint scale_u_m = 256;
	longint scale_v_m = 256;
	int gap = 0;
	bit quiet = 1'b0;
	int errors = 0;
	int words_sent = 0;
	int words_checked = 0;
	int mode_hits [4] = '{0, 0, 0, 0};

	vertex_uv_texture_coordinate_generator u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .vertex(vertex),
		.done(done), .result(result), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	function automatic longint sat32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned n);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > n) bitv >>= 2;
		while (bitv != 0) begin
			if (n >= res + bitv) begin
				n -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic longint vector_angle(longint x, longint y);
		longint ang, dx, dy;
		int n;
		ang = 0;
		n = CORDIC_STAGES > 24 ? 24 : CORDIC_STAGES;
		for (int i = 0; i < n; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y >= 0) begin
				x += dx; y -= dy; ang += ATAN_TAB[i];
			end else begin
				x -= dx; y += dy; ang -= ATAN_TAB[i];
			end
		end
		if (ang < 0) ang = 0;
		if (ang > HALF_PI) ang = HALF_PI;
		return ang;
	endfunction

	function automatic longint scale_angle(longint ang, longint sc);
		return sat32((ang * sc + 32768) >>> 16);
	endfunction

	function automatic result_t texcoord(vertex_t w);
		longint x, y, z, nx, ny, nz, ax, ay, az, a, b, u, v;
		longint unsigned rho;
		result_t r;
		x = w.pos_x; y = w.pos_y; z = w.pos_z;
		nx = w.normal_x; ny = w.normal_y; nz = w.normal_z;
		u = 0; v = 0;
		case (mode_m)
			MODE_SPH: begin
				if (x < EPS_Q8 && x > -EPS_Q8 && z < EPS_Q8 && z > -EPS_Q8) begin
					x = EPS_Q8;
					z = EPS_Q8;
				end
				ax = x < 0 ? -x : x;
				az = z < 0 ? -z : z;
				ay = y < 0 ? -y : y;
				a = vector_angle(az << 24, ax << 24);
				u = scale_angle(a, scale_u_m);
				rho = int_sqrt(longint'(ax * ax + az * az) << 32);
				b = vector_angle(ay << 24, longint'(rho));
				if (y < 0) b = PI_VAL - b;
				v = scale_angle(b, scale_v_m);
			end
			MODE_PLANAR: begin
				u = sat32(x * scale_u_m);
				v = sat32(y * scale_v_m);
			end
			MODE_BOX: begin
				ax = nx < 0 ? -nx : nx;
				ay = ny < 0 ? -ny : ny;
				az = nz < 0 ? -nz : nz;
				if (az > ax && az > ay) begin
					u = sat32(x * scale_u_m);
					v = sat32(y * scale_v_m);
				end else if (ay > ax) begin
					u = sat32(x * scale_u_m);
					v = sat32(-z * scale_v_m);
				end else begin
					u = sat32(-z * scale_u_m);
					v = sat32(y * scale_v_m);
				end
			end
			default: begin
				u = 0;
				v = 0;
			end
		endcase
		r.tex_u = u[31:0];
		r.tex_v = v[31:0];
		return r;
	endfunction

	function automatic logic [15:0] pick_field();
		case ($urandom_range(0, 5))
			0: return 16'($urandom_range(0, 80) - 40);
			1: case ($urandom_range(0, 3))
				0: return 16'h8000;
				1: return 16'h7fff;
				2: return 16'h0000;
				default: return 16'hffff;
			endcase
			2: return 16'($urandom_range(0, 3) < 2 ? 25 + $urandom_range(0, 1)
				: -25 - $urandom_range(0, 1));
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic vertex_t mk(int x, int y, int z, int nx, int ny, int nz);
		vertex_t w;
		w.pos_x = 16'(x); w.pos_y = 16'(y); w.pos_z = 16'(z);
		w.normal_x = 16'(nx); w.normal_y = 16'(ny); w.normal_z = 16'(nz);
		return w;
	endfunction

	function automatic vertex_t random_word();
		vertex_t w;
		logic [15:0] m;
		w.pos_x = pick_field(); w.pos_y = pick_field(); w.pos_z = pick_field();
		w.normal_x = pick_field(); w.normal_y = pick_field(); w.normal_z = pick_field();
		// force box ties on some words
		if ($urandom_range(0, 3) == 0) begin
			m = 16'($urandom_range(0, 32767));
			w.normal_x = $urandom_range(0, 1) ? m : -m;
			if ($urandom_range(0, 1)) w.normal_y = $urandom_range(0, 1) ? m : -m;
			else w.normal_z = $urandom_range(0, 1) ? m : -m;
		end
		return w;
	endfunction

	task automatic cfg_write(logic [1:0] idx, logic [15:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= data;
		case (idx)
			REG_MODE:    mode_m = data[1:0];
			REG_SCALE_U: scale_u_m = longint'($signed(data));
			REG_SCALE_V: scale_v_m = longint'($signed(data));
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic drain();
		wait (pending_words.size() == 0 && !start);
		wait (expected_uv.size() == 0);
		repeat (LAT + 8) @(posedge clk);
	endtask

	// driver: hold the front word until accepted, then advance
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				expected_uv.push_back(texcoord(vertex));
				mode_hits[mode_m]++;
				words_sent++;
				void'(pending_words.pop_front());
			end
			if (gap > 0) gap--;
			else if (!quiet && $urandom_range(0, 11) == 0) gap = $urandom_range(1, 10);
			if (gap == 0 && pending_words.size() > 0) begin
				start <= 1'b1;
				vertex <= pending_words[0];
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_uv.size() == 0) begin
				$error("unexpected result word u=%0d v=%0d", result.tex_u, result.tex_v);
				errors++;
			end else begin
				if (result.tex_u !== expected_uv[0].tex_u) begin
					$error("tex_u expected %0d actual %0d", expected_uv[0].tex_u, result.tex_u);
					errors++;
				end
				if (result.tex_v !== expected_uv[0].tex_v) begin
					$error("tex_v expected %0d actual %0d", expected_uv[0].tex_v, result.tex_v);
					errors++;
				end
				void'(expected_uv.pop_front());
				words_checked++;
			end
		end
	end

	initial begin
		logic [1:0] modes [NUM_PHASES] = '{MODE_SPH, MODE_PLANAR, MODE_BOX, MODE_NONE,
			MODE_SPH, MODE_PLANAR, MODE_BOX, MODE_SPH, MODE_BOX, MODE_PLANAR,
			MODE_SPH, MODE_BOX, MODE_PLANAR, MODE_SPH, MODE_BOX, MODE_SPH};
		logic [15:0] su [NUM_PHASES] = '{16'd256, 16'h7fff, 16'h8000, 16'h1234,
			16'h8000, 16'h0000, 16'hffff, 16'h7fff, 16'h0100, 16'h8000,
			16'h0000, 16'h7fff, 16'hffff, 16'hffff, 16'h0000, 16'h0100};
		logic [15:0] sv [NUM_PHASES] = '{16'd256, 16'h8000, 16'h7fff, 16'h4321,
			16'h7fff, 16'hffff, 16'h0000, 16'h8000, 16'h0100, 16'h7fff,
			16'h0001, 16'h8000, 16'h0000, 16'hffff, 16'h7fff, 16'h0100};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int p = 0; p < NUM_PHASES; p++) begin
			if (p > 0) begin
				cfg_write(REG_MODE, {14'($urandom), modes[p]});
				cfg_write(REG_SCALE_U, (p >= 7 && p % 3 == 1) ? 16'($urandom) : su[p]);
				cfg_write(REG_SCALE_V, (p >= 7 && p % 3 == 2) ? 16'($urandom) : sv[p]);
				if (p == 3) cfg_write(REG_UNUSED, 16'($urandom));
			end
			if (p == 0) begin
				pending_words.push_back(mk(32767, 32767, 32767, 0, 0, 0));
				pending_words.push_back(mk(-32768, -32768, -32768, -32768, -32768, -32768));
				pending_words.push_back(mk(0, 0, 0, 0, 0, 0));
				pending_words.push_back(mk(10, 500, -20, 0, 0, 0));
				pending_words.push_back(mk(25, -300, -25, 0, 0, 0));
				pending_words.push_back(mk(26, 100, 0, 0, 0, 0));
				pending_words.push_back(mk(-26, 100, 25, 0, 0, 0));
				pending_words.push_back(mk(3000, 0, 0, 0, 0, 0));
				pending_words.push_back(mk(3000, 0, 4000, 0, 0, 0));
				pending_words.push_back(mk(-3000, -7000, 4000, 0, 0, 0));
				pending_words.push_back(mk(0, -32768, 5, 0, 0, 0));
				pending_words.push_back(mk(-1, 32767, -1, 0, 0, 0));
			end
			if (p == 2) begin
				pending_words.push_back(mk(1000, 2000, 3000, 100, 100, 100));
				pending_words.push_back(mk(1000, 2000, 3000, 100, -100, 50));
				pending_words.push_back(mk(1000, 2000, 3000, 50, 100, -100));
				pending_words.push_back(mk(1000, 2000, 3000, -100, 50, 100));
				pending_words.push_back(mk(1000, 2000, 3000, 10, 20, -30));
				pending_words.push_back(mk(1000, 2000, 3000, 10, -30, 20));
				pending_words.push_back(mk(-32768, 32767, -32768, -32768, 0, 32767));
				pending_words.push_back(mk(32767, -32768, -32768, 0, 0, -32768));
			end
			if (p >= NUM_PHASES - 2) quiet = 1'b1;
			for (int k = 0; k < RAND_PER_PHASE; k++) pending_words.push_back(random_word());
			drain();
		end
		$display("covered %0d vertex words over %0d settings, all four modes (%0d/%0d/%0d/%0d)",
			words_sent, NUM_PHASES, mode_hits[0], mode_hits[1], mode_hits[2], mode_hits[3]);
		$display("checked %0d result words, %0d mismatches", words_checked, errors);
		if (errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	initial begin
		#4ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

### vertex_uv_texture_coordinate_generator.f
rtl/uvgen_pkg.sv
rtl/uvgen_isqrt.sv
rtl/uvgen_cordic.sv
rtl/uvgen_scale.sv
rtl/vertex_uv_texture_coordinate_generator.sv
tb/vertex_uv_texture_coordinate_generator_test.sv
